[rtl/gecn_pkg.sv]
// Shared constants, types and controller/datapath interface structs for the empty cell nibbler.
package gecn_pkg;

   localparam int MAX_COLS   = 256;
   localparam int MAX_ROWS   = 256;
   localparam int MAX_RADIUS = 63;

   localparam int COL_W = $clog2(MAX_COLS);
   localparam int ROW_W = $clog2(MAX_ROWS);
   localparam int DIM_W = 9;
   localparam int RAD_W = 6;
   localparam int CSR_W = 9;
   localparam int IDX_W = 2;

   localparam logic [DIM_W-1:0] COLS_LIM   = DIM_W'(MAX_COLS);
   localparam logic [DIM_W-1:0] ROWS_LIM   = DIM_W'(MAX_ROWS);
   localparam logic [RAD_W-1:0] RADIUS_LIM = RAD_W'(MAX_RADIUS);

   // item command codes
   localparam logic CMD_WRITE = 1'b0;
   localparam logic CMD_QUERY = 1'b1;

   typedef enum logic [IDX_W-1:0] {
      CSR_GRID_WIDTH  = 2'd0,
      CSR_GRID_HEIGHT = 2'd1,
      CSR_RADIUS      = 2'd2
   } csr_idx_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SETUP,
      ST_SCAN,
      ST_DRAIN,
      ST_WR_READ,
      ST_WR_WRITE,
      ST_RESP
   } state_type;

   typedef struct packed {
      logic capture;
      logic setup;
      logic scan_issue;
      logic wr_issue;
      logic wr_commit;
      logic rsp_load;
   } dp_cmd_type;

   typedef struct packed {
      logic oor;
      logic is_write;
      logic scan_last;
      logic rsp_busy;
   } dp_sts_type;

endpackage

[rtl/gecn_ctrl.sv]
// Controller state machine sequencing write, scan and response steps.
module gecn_ctrl import gecn_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  dp_sts_type sts,
   output dp_cmd_type cmd
);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_SETUP;
         end
         ST_SETUP: begin
            if (sts.oor)           state_in = ST_RESP;
            else if (sts.is_write) state_in = ST_WR_READ;
            else                   state_in = ST_SCAN;
         end
         ST_SCAN: begin
            if (sts.scan_last) state_in = ST_DRAIN;
         end
         ST_DRAIN:    state_in = ST_RESP;
         ST_WR_READ:  state_in = ST_WR_WRITE;
         ST_WR_WRITE: state_in = ST_RESP;
         ST_RESP: begin
            if (!sts.rsp_busy) state_in = ST_IDLE;
         end
         default:     state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd            = '0;
      req_ready      = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready   = 1'b1;
            cmd.capture = req_valid;
         end
         ST_SETUP:    cmd.setup      = 1'b1;
         ST_SCAN:     cmd.scan_issue = 1'b1;
         ST_DRAIN:    ;
         ST_WR_READ:  cmd.wr_issue   = 1'b1;
         ST_WR_WRITE: cmd.wr_commit  = 1'b1;
         ST_RESP:     cmd.rsp_load   = !sts.rsp_busy;
         default:     ;
      endcase
   end

endmodule

[rtl/gecn_dp.sv]
// Datapath: config registers, row-word bitmap memory, window mask, scan accumulator, result register.
module gecn_dp import gecn_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_we,
   input  logic [IDX_W-1:0] csr_index,
   input  logic [CSR_W-1:0] csr_wdata,
   input  logic             req_command,
   input  logic [ROW_W-1:0] req_row,
   input  logic [COL_W-1:0] req_col,
   input  logic             req_has_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output logic             rsp_clear_interpolated,
   output logic             rsp_out_of_range,
   input  dp_cmd_type       cmd,
   output dp_sts_type       sts
);

   // configuration
   logic [DIM_W-1:0] width_ff;
   logic [DIM_W-1:0] height_ff;
   logic [RAD_W-1:0] radius_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= DIM_W'(256);
         height_ff <= DIM_W'(256);
         radius_ff <= '0;
      end else if (csr_we) begin
         unique case (csr_idx_type'(csr_index))
            CSR_GRID_WIDTH:  width_ff  <= csr_wdata[DIM_W-1:0];
            CSR_GRID_HEIGHT: height_ff <= csr_wdata[DIM_W-1:0];
            CSR_RADIUS:      radius_ff <= csr_wdata[RAD_W-1:0];
            default:         ;
         endcase
      end
   end

   logic [DIM_W-1:0] w_eff;
   logic [DIM_W-1:0] h_eff;
   logic [RAD_W-1:0] r_eff;

   assign w_eff = (width_ff  > COLS_LIM)   ? COLS_LIM   : width_ff;
   assign h_eff = (height_ff > ROWS_LIM)   ? ROWS_LIM   : height_ff;
   assign r_eff = (radius_ff > RADIUS_LIM) ? RADIUS_LIM : radius_ff;

   // captured transaction
   logic             item_cmd_ff;
   logic [ROW_W-1:0] item_row_ff;
   logic [COL_W-1:0] item_col_ff;
   logic             item_data_ff;
   logic             oor_ff;
   logic             oor_in;

   assign oor_in = ({1'b0, req_row} >= h_eff) || ({1'b0, req_col} >= w_eff);

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         item_cmd_ff  <= req_command;
         item_row_ff  <= req_row;
         item_col_ff  <= req_col;
         item_data_ff <= req_has_data;
         oor_ff       <= oor_in;
      end
   end

   // window bounds, clipped to the grid
   logic [DIM_W-1:0] row_hi_sum;
   logic [DIM_W-1:0] col_hi_sum;
   logic [DIM_W-1:0] h_last;
   logic [DIM_W-1:0] w_last;
   logic [ROW_W-1:0] row_lo;
   logic [ROW_W-1:0] row_hi;
   logic [COL_W-1:0] col_lo;
   logic [COL_W-1:0] col_hi;
   logic [MAX_COLS-1:0] mask_in;

   assign row_hi_sum = {1'b0, item_row_ff} + DIM_W'(r_eff);
   assign col_hi_sum = {1'b0, item_col_ff} + DIM_W'(r_eff);
   assign h_last     = h_eff - DIM_W'(1);
   assign w_last     = w_eff - DIM_W'(1);
   assign row_lo     = ({1'b0, item_row_ff} > DIM_W'(r_eff)) ?
                       (item_row_ff - ROW_W'(r_eff)) : '0;
   assign col_lo     = ({1'b0, item_col_ff} > DIM_W'(r_eff)) ?
                       (item_col_ff - COL_W'(r_eff)) : '0;
   assign row_hi     = (row_hi_sum > h_last) ? h_last[ROW_W-1:0] : row_hi_sum[ROW_W-1:0];
   assign col_hi     = (col_hi_sum > w_last) ? w_last[COL_W-1:0] : col_hi_sum[COL_W-1:0];

   // ones from col_lo up to col_hi inclusive
   assign mask_in = ({MAX_COLS{1'b1}} << col_lo) &
                    ({MAX_COLS{1'b1}} >> (COL_W'(MAX_COLS - 1) - col_hi));

   logic [MAX_COLS-1:0] mask_ff;
   logic [ROW_W-1:0]    row_end_ff;
   logic [ROW_W-1:0]    scan_row_ff;

   always_ff @(posedge clock) begin
      if (cmd.setup) begin
         mask_ff     <= mask_in;
         row_end_ff  <= row_hi;
         scan_row_ff <= row_lo;
      end else if (cmd.scan_issue) begin
         scan_row_ff <= scan_row_ff + ROW_W'(1);
      end
   end

   // bitmap: one 256-bit word per row; a row never written reads as empty
   logic [MAX_COLS-1:0] mem [MAX_ROWS];
   logic [MAX_ROWS-1:0] row_vld_ff;
   logic [ROW_W-1:0]    rd_addr;
   logic                rd_en;
   logic [MAX_COLS-1:0] rd_data_ff;
   logic                rd_vld_ff;
   logic                rd_pend_ff;
   logic [MAX_COLS-1:0] rd_word;
   logic [MAX_COLS-1:0] wr_word;

   assign rd_addr = cmd.scan_issue ? scan_row_ff : item_row_ff;
   assign rd_en   = cmd.scan_issue || cmd.wr_issue;
   assign rd_word = rd_vld_ff ? rd_data_ff : '0;

   always_comb begin
      wr_word              = rd_word;
      wr_word[item_col_ff] = item_data_ff;
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
      if (cmd.wr_commit) begin
         mem[item_row_ff] <= wr_word;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_vld_ff <= '0;
         rd_vld_ff  <= 1'b0;
         rd_pend_ff <= 1'b0;
      end else begin
         if (rd_en) begin
            rd_vld_ff <= row_vld_ff[rd_addr];
         end
         if (cmd.wr_commit) begin
            row_vld_ff[item_row_ff] <= 1'b1;
         end
         rd_pend_ff <= cmd.scan_issue;
      end
   end

   // window accumulator; the queried cell lies inside its own window
   logic found_ff;

   always_ff @(posedge clock) begin
      if (cmd.setup) begin
         found_ff <= 1'b0;
      end else if (rd_pend_ff) begin
         found_ff <= found_ff | (|(rd_word & mask_ff));
      end
   end

   // result register
   logic rsp_valid_ff;
   logic clr_ff;
   logic rsp_oor_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         clr_ff     <= (item_cmd_ff == CMD_QUERY) && !oor_ff && !found_ff;
         rsp_oor_ff <= oor_ff;
      end
   end

   assign rsp_valid              = rsp_valid_ff;
   assign rsp_clear_interpolated = clr_ff;
   assign rsp_out_of_range       = rsp_oor_ff;

   assign sts.oor       = oor_ff;
   assign sts.is_write  = (item_cmd_ff == CMD_WRITE);
   assign sts.scan_last = (scan_row_ff == row_end_ff);
   assign sts.rsp_busy  = rsp_valid_ff && !rsp_ready;

endmodule

[rtl/grid_empty_cell_nibbler_unit.sv]
// Steps: query = setup, scan of each window row, drain, response; write = setup, read,
//   write, response; out of range = setup, response. One transaction at a time; the query
//   scan reads one bitmap row word per cycle from the single-port row memory.
// A finished result waits in the output register while the next transaction is accepted.
// Reset (synchronous, active high): grid 256 x 256, radius 0, per-row valid flags cleared so
//   the whole bitmap reads empty at once; no clearing pass.
module grid_empty_cell_nibbler_unit import gecn_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_we,
   input  logic [IDX_W-1:0] csr_index,
   input  logic [CSR_W-1:0] csr_wdata,
   input  logic             req_valid,
   output logic             req_ready,
   input  logic             req_command,
   input  logic [ROW_W-1:0] req_row,
   input  logic [COL_W-1:0] req_col,
   input  logic             req_has_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output logic             rsp_clear_interpolated,
   output logic             rsp_out_of_range
);

   dp_cmd_type cmd;
   dp_sts_type sts;

   gecn_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   gecn_dp u_dp (
      .clock                  (clock),
      .reset                  (reset),
      .csr_we                 (csr_we),
      .csr_index              (csr_index),
      .csr_wdata              (csr_wdata),
      .req_command            (req_command),
      .req_row                (req_row),
      .req_col                (req_col),
      .req_has_data           (req_has_data),
      .rsp_valid              (rsp_valid),
      .rsp_ready              (rsp_ready),
      .rsp_clear_interpolated (rsp_clear_interpolated),
      .rsp_out_of_range       (rsp_out_of_range),
      .cmd                    (cmd),
      .sts                    (sts)
   );

   // an out-of-range cell never asks for its value to be cleared
   a_clr_not_oor: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_clear_interpolated && rsp_out_of_range))
      else $error("clear flag set on out-of-range transaction");

   // accepting a transaction makes the block busy on the next cycle
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("block ready right after accepting a transaction");

   // a new result only appears from the response step, never while idle
   a_rsp_from_busy: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(!req_ready))
      else $error("result appeared without a transaction in flight");

   // a data row is written only as part of a write transaction that is in range
   a_commit_in_range: assert property (@(posedge clock) disable iff (reset)
      cmd.wr_commit |-> (sts.is_write && !sts.oor))
      else $error("bitmap write for out-of-range or query transaction");

endmodule
